[rtl/sopq_pkg.sv]
// Shared sizes, entry layout, operation and status codes and FSM states
// for the sorted open list priority queue. No dependencies.
package sopq_pkg;

  localparam int DEPTH     = 64;
  localparam int ID_BITS   = 12;
  localparam int COST_BITS = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ENTRY_W   = ID_BITS + 2 * COST_BITS;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [COST_BITS-1:0] fcost;
    logic [COST_BITS-1:0] hcost;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_OUT
  } state_t;

endpackage

[rtl/sopq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sopq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sorted_open_list_priority_queue.sv]
// Sorted open list priority queue: sequencer over one entry RAM.
// Depends on sopq_pkg and sopq_ram.
// Each entry visited takes a read state and a compare or write state on the single RAM
// read port; a full insert, or a remove/pop/query on an empty list, goes straight to the
// result, held while the output stalls. One item at a time: next accept after the result.
// Reset: synchronous, clears the entry count and output valid; RAM is not cleared.
module sorted_open_list_priority_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [sopq_pkg::ID_BITS-1:0]   in_node_id,
  input  logic [sopq_pkg::COST_BITS-1:0] in_total_cost,
  input  logic [sopq_pkg::COST_BITS-1:0] in_heur_cost,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sopq_pkg::ID_BITS-1:0]   out_id,
  output logic [1:0]                    out_status,
  output logic                          out_list_empty
);
  import sopq_pkg::*;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  entry_t               new_r, new_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [ID_BITS-1:0]   res_id_r, res_id_nxt;
  logic [1:0]           res_stat_r, res_stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_BITS-1:0]   out_id_r, out_id_nxt;
  logic [1:0]           out_stat_r, out_stat_nxt;
  logic                 out_empty_r, out_empty_nxt;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  entry_t               wdata;
  entry_t               rdata;
  logic [ENTRY_W-1:0]   rdata_raw;
  logic [CNT_W-1:0]     pos_p1, pos_m1;
  logic                 last;
  logic                 new_less;
  logic                 out_free;

  sopq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(pos_r[ADDR_W-1:0]),
    .rdata(rdata_raw)
  );

  assign rdata    = entry_t'(rdata_raw);
  assign pos_p1   = pos_r + CNT_W'(1);
  assign pos_m1   = pos_r - CNT_W'(1);
  assign last     = (pos_p1 == count_r);
  assign new_less = (new_r.fcost < rdata.fcost) ||
                    ((new_r.fcost == rdata.fcost) && (new_r.hcost < rdata.hcost));
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    new_r       <= new_nxt;
    pos_r       <= pos_nxt;
    res_id_r    <= res_id_nxt;
    res_stat_r  <= res_stat_nxt;
    out_id_r    <= out_id_nxt;
    out_stat_r  <= out_stat_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    new_nxt       = new_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    res_id_nxt    = res_id_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_stat_nxt  = out_stat_r;
    out_empty_nxt = out_empty_r;
    we            = 1'b0;
    waddr         = pos_r[ADDR_W-1:0];
    wdata         = new_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_op);
          new_nxt      = '{id: in_node_id, fcost: in_total_cost, hcost: in_heur_cost};
          res_id_nxt   = '0;
          res_stat_nxt = STAT_OK;
          if (op_t'(in_op) == OP_INSERT) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_stat_nxt = STAT_FULL;
              state_nxt    = ST_OUT;
            end else if (count_r == '0) begin
              pos_nxt   = '0;
              state_nxt = ST_INS_PUT;
            end else begin
              pos_nxt   = count_r - CNT_W'(1);
              state_nxt = ST_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = STAT_EMPTY;
              state_nxt    = ST_OUT;
            end else begin
              pos_nxt   = '0;
              state_nxt = ST_SCAN_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        we    = 1'b1;
        waddr = pos_p1[ADDR_W-1:0];
        if (new_less) begin
          wdata = rdata;
          if (pos_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            pos_nxt   = pos_m1;
            state_nxt = ST_INS_RD;
          end
        end else begin
          wdata     = new_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_OUT;
        end
      end
      ST_INS_PUT: begin
        we        = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_OUT;
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (op_r == OP_POP || rdata.id == new_r.id) begin
          if (op_r == OP_QUERY) begin
            state_nxt = ST_OUT;
          end else begin
            if (op_r == OP_POP) begin
              res_id_nxt = rdata.id;
            end
            if (last) begin
              count_nxt = count_r - CNT_W'(1);
              state_nxt = ST_OUT;
            end else begin
              pos_nxt   = pos_p1;
              state_nxt = ST_SHF_RD;
            end
          end
        end else if (last) begin
          res_stat_nxt = STAT_EMPTY;
          state_nxt    = ST_OUT;
        end else begin
          pos_nxt   = pos_p1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SHF_RD: begin
        state_nxt = ST_SHF_WR;
      end
      ST_SHF_WR: begin
        we    = 1'b1;
        waddr = pos_m1[ADDR_W-1:0];
        wdata = rdata;
        if (last) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_OUT;
        end else begin
          pos_nxt   = pos_p1;
          state_nxt = ST_SHF_RD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_stat_nxt  = res_stat_r;
          out_empty_nxt = (count_r == '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_id         = out_id_r;
  assign out_status     = out_stat_r;
  assign out_list_empty = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS_PUT |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> !out_list_empty)
    else $error("full result reports an empty list");

  a_id_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_id != '0 |-> out_status == STAT_OK)
    else $error("identifier returned with a failing status");

endmodule

[tb/sv/sorted_open_list_priority_queue_tb.sv]
// Self-checking testbench for sorted_open_list_priority_queue: directed and
// random insert/remove/pop/query items checked against an open-list predictor.
// Depends on sopq_pkg and the queue RTL.
module sorted_open_list_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sopq_pkg::*;

  localparam int CYCLE_LIMIT  = 1200000;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 8;

  typedef struct {
    op_t                  op;
    logic [ID_BITS-1:0]   node_id;
    logic [COST_BITS-1:0] total_cost;
    logic [COST_BITS-1:0] heur_cost;
  } list_op_t;

  typedef struct {
    logic [ID_BITS-1:0] id;
    logic [1:0]         status;
    logic               list_empty;
  } list_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_op = OP_QUERY;
  logic [ID_BITS-1:0]   in_node_id = '0;
  logic [COST_BITS-1:0] in_total_cost = '0;
  logic [COST_BITS-1:0] in_heur_cost = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ID_BITS-1:0]   out_id;
  logic [1:0]           out_status;
  logic                 out_list_empty;

  entry_t       open_list[$];
  list_op_t     pending_ops[$];
  list_result_t awaited_results[$];
  list_op_t     next_op;
  list_result_t want;
  int           err_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_pct = 0;
  int           stall_mode_left = 0;
  int           stall_levels[4] = '{0, 25, 60, 90};
  int           cycle_count = 0;

  sorted_open_list_priority_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_node_id     (in_node_id),
    .in_total_cost  (in_total_cost),
    .in_heur_cost   (in_heur_cost),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_id         (out_id),
    .out_status     (out_status),
    .out_list_empty (out_list_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_id(input logic [ID_BITS-1:0] id);
    for (int i = 0; i < open_list.size(); i++) begin
      if (open_list[i].id == id) return i;
    end
    return -1;
  endfunction

  function automatic list_result_t open_list_apply(input list_op_t item);
    list_result_t res;
    entry_t       e;
    int           pos;
    res.id = '0;
    res.status = STAT_OK;
    case (item.op)
      OP_INSERT: begin
        if (open_list.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < open_list.size() &&
                 !(item.total_cost < open_list[pos].fcost ||
                   (item.total_cost == open_list[pos].fcost &&
                    item.heur_cost < open_list[pos].hcost)))
            pos++;
          e.id = item.node_id;
          e.fcost = item.total_cost;
          e.hcost = item.heur_cost;
          open_list.insert(pos, e);
        end
      end
      OP_REMOVE: begin
        pos = find_id(item.node_id);
        if (pos < 0) res.status = STAT_EMPTY;
        else open_list.delete(pos);
      end
      OP_POP: begin
        if (open_list.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          e = open_list.pop_front();
          res.id = e.id;
        end
      end
      default: begin
        res.status = (find_id(item.node_id) < 0) ? STAT_EMPTY : STAT_OK;
      end
    endcase
    res.list_empty = (open_list.size() == 0);
    return res;
  endfunction

  function automatic logic [COST_BITS-1:0] rand_cost();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return COST_BITS'($urandom_range(0, 3));
      4:          return {COST_BITS{1'b1}} - COST_BITS'($urandom_range(0, 1));
      default:    return COST_BITS'($urandom_range(0, (1 << COST_BITS) - 1));
    endcase
  endfunction

  task automatic queue_item(input op_t op, input int id, input int f, input int h);
    list_op_t item;
    item.op = op;
    item.node_id = ID_BITS'(id);
    item.total_cost = COST_BITS'(f);
    item.heur_cost = COST_BITS'(h);
    pending_ops.push_back(item);
  endtask

  task automatic queue_random(input int count, input int ins_pct, input int rem_pct,
                              input int pop_pct);
    int roll;
    int id;
    op_t op;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + rem_pct) op = OP_REMOVE;
      else if (roll < ins_pct + rem_pct + pop_pct) op = OP_POP;
      else op = OP_QUERY;
      id = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, (1 << ID_BITS) - 1);
      queue_item(op, id, rand_cost(), rand_cost());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        awaited_results.push_back(open_list_apply('{op: op_t'(in_op), node_id: in_node_id,
                                                    total_cost: in_total_cost,
                                                    heur_cost: in_heur_cost}));
      if (gap_left != 0 || pending_ops.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        next_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_op <= next_op.op;
        in_node_id <= next_op.node_id;
        in_total_cost <= next_op.total_cost;
        in_heur_cost <= next_op.heur_cost;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_pct <= stall_levels[$urandom_range(0, 3)];
      stall_mode_left <= $urandom_range(50, 400);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: out_id %0d out_status %0d", out_id, out_status);
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_id !== want.id) begin
          $error("out_id: expected %0d, got %0d", want.id, out_id);
          err_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
        if (out_list_empty !== want.list_empty) begin
          $error("out_list_empty: expected %0d, got %0d", want.list_empty, out_list_empty);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_open_list_priority_queue_tb: errors");
      $finish;
    end
  end

  initial begin
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_REMOVE, 4095, 0, 0);
    queue_item(OP_QUERY, 0, 0, 0);
    queue_item(OP_INSERT, 4095, 65535, 65535);
    queue_item(OP_INSERT, 0, 0, 0);
    queue_item(OP_INSERT, 5, 100, 7);
    queue_item(OP_INSERT, 6, 100, 7);
    queue_item(OP_INSERT, 7, 100, 3);
    queue_item(OP_INSERT, 5, 100, 7);
    queue_item(OP_INSERT, 2730, 'hAAAA, 'h5555);
    queue_item(OP_QUERY, 6, 0, 0);
    queue_item(OP_QUERY, 9, 0, 0);
    queue_item(OP_REMOVE, 9, 0, 0);
    queue_item(OP_REMOVE, 4095, 0, 0);
    queue_item(OP_REMOVE, 5, 0, 0);
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_POP, 0, 0, 0);
    queue_item(OP_INSERT, 1365, 'h5555, 'hAAAA);
    queue_item(OP_REMOVE, 1365, 0, 0);
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0:       queue_random(120, 85, 5, 5);
        1:       queue_random(120, 10, 20, 65);
        default: queue_random(120, 40, 20, 20);
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("results still awaited at end: %0d", awaited_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("sorted_open_list_priority_queue_tb: clean");
    end else begin
      $display("sorted_open_list_priority_queue_tb: errors");
    end
    $finish;
  end

endmodule
